FILE: rtl/dtpb_pkg.sv
// ============================================================================
// dtpb_pkg
// Shared types and constants of the depth-tested pixel buffer.
// ============================================================================
`default_nettype none

package dtpb_pkg;

    // Default store geometry
    localparam int MAX_WIDTH_DEF  = 512;
    localparam int MAX_HEIGHT_DEF = 512;

    // Field widths
    localparam int COORD_W  = 12;
    localparam int DEPTH_W  = 16;
    localparam int COLOR_W  = 8;
    localparam int RGB_W    = 3 * COLOR_W;
    localparam int SIZE_W   = 10;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W = 1;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 24;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 10'd512;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] RES_WRITTEN  = 3'd0;
    localparam logic [STATUS_W-1:0] RES_REJECTED = 3'd1;
    localparam logic [STATUS_W-1:0] RES_OUT      = 3'd2;
    localparam logic [STATUS_W-1:0] RES_READ     = 3'd3;
    localparam logic [STATUS_W-1:0] RES_CLEARED  = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'd1;

    localparam logic [RGB_W-1:0]   WHITE_RGB = 24'hFF_FFFF;
    localparam logic [DEPTH_W-1:0] FAR_DEPTH = 16'hFFFF;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_item;    // capture the input item and read its pixel
        logic commit;       // finish a write, read or unused-kind item and load the result
        logic sweep_write;  // write one blank pixel at the sweep pointer
        logic load_clear;   // load the result of a clear
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic in_is_clear;  // item on the input is a clear
        logic sweep_last;   // sweep pointer is at the final pixel
    } stat_t;

endpackage

`default_nettype wire

FILE: rtl/depth_tested_pixel_buffer_core.sv
// ============================================================================
// depth_tested_pixel_buffer_core
// Color framebuffer with a 16-bit depth test, read port and full clear.
// ============================================================================
//
// Channel   Direction  Payload
// s_axis    in         tuser: kind; tdata: pos_x, pos_y, depth_in, red, green, blue
// m_axis    out        tuser: status; tdata: red_out, green_out, blue_out
// cfg       in         cfg_index 0 width, 1 height; cfg_data 10 bits
//
// A write, read or unused-kind item reads the pixel store in the accept
// cycle (registered read); S_DECIDE then, once the result register is free,
// does the depth compare and the write-back on the single store port.
// A clear sweeps every pixel, one pixel written per cycle, then waits in
// S_DONE for a free result register. After reset the store is blanked by
// the same sweep, with s_axis_tready low.
// The result register holds a finished transaction while the next item is
// taken; a stalled m_axis holds the commit of the following item.
// ============================================================================
`default_nettype none

module depth_tested_pixel_buffer_core #(
    parameter int MAX_WIDTH  = dtpb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = dtpb_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,

    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // [11:0] pos_x, [23:12] pos_y, [39:24] depth_in,
    // [47:40] red_in, [55:48] green_in, [63:56] blue_in
    input  wire logic [dtpb_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // [1:0] kind
    input  wire logic [dtpb_pkg::KIND_W-1:0]          s_axis_tuser,

    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // [7:0] red_out, [15:8] green_out, [23:16] blue_out
    output logic      [dtpb_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // [2:0] status
    output logic      [dtpb_pkg::STATUS_W-1:0]        m_axis_tuser,

    input  wire logic                                 cfg_we,
    input  wire logic [dtpb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [dtpb_pkg::SIZE_W-1:0]          cfg_data
);

    dtpb_pkg::cmd_t  cmd;
    dtpb_pkg::stat_t stat;

    dtpb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .stat      (stat),
        .cmd       (cmd),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready)
    );

    dtpb_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_kind    (s_axis_tuser),
        .in_data    (s_axis_tdata),
        .out_status (m_axis_tuser),
        .out_data   (m_axis_tdata)
    );

endmodule

`default_nettype wire

FILE: rtl/dtpb_datapath.sv
// ============================================================================
// dtpb_datapath
// Configuration registers, pixel store, depth compare and result register.
// ============================================================================
`default_nettype none

module dtpb_datapath #(
    parameter int MAX_WIDTH  = dtpb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = dtpb_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire dtpb_pkg::cmd_t                       cmd,
    output dtpb_pkg::stat_t                           stat,
    input  wire logic                                 cfg_we,
    input  wire logic [dtpb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [dtpb_pkg::SIZE_W-1:0]          cfg_data,
    input  wire logic [dtpb_pkg::KIND_W-1:0]          in_kind,
    input  wire logic [dtpb_pkg::IN_DATA_W-1:0]       in_data,
    output logic      [dtpb_pkg::STATUS_W-1:0]        out_status,
    output logic      [dtpb_pkg::OUT_DATA_W-1:0]      out_data
);

    localparam int PIX   = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (PIX > 1) ? $clog2(PIX) : 1;
    localparam int MEM_W = dtpb_pkg::RGB_W + dtpb_pkg::DEPTH_W;
    localparam int PROD_W = 26;
    localparam logic [12:0] MAXW13 = 13'(MAX_WIDTH);
    localparam logic [12:0] MAXH13 = 13'(MAX_HEIGHT);
    localparam logic [AW-1:0] LAST_ADDR = AW'(PIX - 1);

    logic [dtpb_pkg::SIZE_W-1:0]   width_reg;
    logic [dtpb_pkg::SIZE_W-1:0]   height_reg;

    logic [dtpb_pkg::KIND_W-1:0]   kind_reg;
    logic                          in_range_reg;
    logic [AW-1:0]                 addr_reg;
    logic [dtpb_pkg::DEPTH_W-1:0]  depth_reg;
    logic [dtpb_pkg::RGB_W-1:0]    rgb_reg;
    logic [MEM_W-1:0]              rd_reg;
    logic [AW-1:0]                 sweep_cnt_reg;
    logic [AW-1:0]                 sweep_cnt_next;
    logic [dtpb_pkg::STATUS_W-1:0] status_reg;
    logic [dtpb_pkg::RGB_W-1:0]    color_reg;

    logic [MEM_W-1:0]              mem_array [0:PIX-1];

    logic [dtpb_pkg::COORD_W-1:0]  pos_x;
    logic [dtpb_pkg::COORD_W-1:0]  pos_y;
    logic [10:0]                   x_mag;
    logic [10:0]                   y_mag;
    logic                          x_ok;
    logic                          y_ok;
    logic [PROD_W-1:0]             addr_full;
    logic [AW-1:0]                 addr_in;

    logic [dtpb_pkg::RGB_W-1:0]    rd_rgb;
    logic [dtpb_pkg::DEPTH_W-1:0]  rd_depth;
    logic                          depth_pass;
    logic                          item_write;
    logic [dtpb_pkg::STATUS_W-1:0] res_status;
    logic [dtpb_pkg::RGB_W-1:0]    res_color;

    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr;
    logic [MEM_W-1:0]              mem_wdata;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= dtpb_pkg::SIZE_RESET;
            height_reg <= dtpb_pkg::SIZE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dtpb_pkg::REG_WIDTH:  width_reg  <= cfg_data;
                dtpb_pkg::REG_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Bounds check and pixel address of the incoming item
    // ------------------------------------------------------------------
    assign pos_x = in_data[11:0];
    assign pos_y = in_data[23:12];
    assign x_mag = pos_x[10:0];
    assign y_mag = pos_y[10:0];

    // Saturation to the store size is the second compare
    assign x_ok = !pos_x[11] && (x_mag < {1'b0, width_reg}) && (13'(x_mag) < MAXW13);
    assign y_ok = !pos_y[11] && (y_mag < {1'b0, height_reg}) && (13'(y_mag) < MAXH13);

    assign addr_full = PROD_W'(y_mag) * PROD_W'(MAX_WIDTH) + PROD_W'(x_mag);
    assign addr_in   = addr_full[AW-1:0];

    assign stat.in_is_clear = (in_kind == dtpb_pkg::KIND_CLEAR);
    assign stat.sweep_last  = (sweep_cnt_reg == LAST_ADDR);

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            kind_reg     <= in_kind;
            in_range_reg <= x_ok && y_ok;
            addr_reg     <= addr_in;
            depth_reg    <= in_data[39:24];
            rgb_reg      <= {in_data[47:40], in_data[55:48], in_data[63:56]};
        end
    end

    // ------------------------------------------------------------------
    // Pixel store: registered read, one write port
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            rd_reg <= mem_array[addr_in];
        end
    end

    assign rd_rgb     = rd_reg[MEM_W-1:dtpb_pkg::DEPTH_W];
    assign rd_depth   = rd_reg[dtpb_pkg::DEPTH_W-1:0];
    assign depth_pass = (depth_reg <= rd_depth);
    assign item_write = (kind_reg == dtpb_pkg::KIND_WRITE) && in_range_reg && depth_pass;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = {rgb_reg, depth_reg};
        priority if (cmd.sweep_write)
        begin
            mem_we    = 1'b1;
            mem_waddr = sweep_cnt_reg;
            mem_wdata = {dtpb_pkg::WHITE_RGB, dtpb_pkg::FAR_DEPTH};
        end
        else if (cmd.commit && item_write)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_array[mem_waddr] <= mem_wdata;
        end
    end

    // Sweep pointer walks every pixel, wraps after the last one
    assign sweep_cnt_next = stat.sweep_last ? '0 : sweep_cnt_reg + AW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_cnt_reg <= '0;
        end
        else if (cmd.sweep_write)
        begin
            sweep_cnt_reg <= sweep_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Result
    // ------------------------------------------------------------------
    always_comb
    begin
        res_status = dtpb_pkg::RES_OUT;
        res_color  = '0;
        unique case (kind_reg)
            dtpb_pkg::KIND_WRITE:
            begin
                if (in_range_reg)
                begin
                    res_status = depth_pass ? dtpb_pkg::RES_WRITTEN
                                            : dtpb_pkg::RES_REJECTED;
                end
            end
            dtpb_pkg::KIND_READ:
            begin
                if (in_range_reg)
                begin
                    res_status = dtpb_pkg::RES_READ;
                    res_color  = rd_rgb;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_clear)
        begin
            status_reg <= dtpb_pkg::RES_CLEARED;
            color_reg  <= '0;
        end
        else if (cmd.commit)
        begin
            status_reg <= res_status;
            color_reg  <= res_color;
        end
    end

    assign out_status = status_reg;
    // Red in the low byte, blue in the high byte
    assign out_data   = {color_reg[7:0], color_reg[15:8], color_reg[23:16]};

endmodule

`default_nettype wire

FILE: rtl/dtpb_ctrl.sv
// ============================================================================
// dtpb_ctrl
// Sequencer for item lookup, commit, clear sweeps and the result handshake.
// ============================================================================
`default_nettype none

module dtpb_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire dtpb_pkg::stat_t stat,
    output dtpb_pkg::cmd_t       cmd,
    input  wire logic            in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready
);

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_CLEAR  = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;
    logic       accept;

    assign out_free = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        cmd.load_item    = 1'b0;
        cmd.commit       = 1'b0;
        cmd.sweep_write  = 1'b0;
        cmd.load_clear   = 1'b0;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.sweep_write = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = stat.in_is_clear ? S_CLEAR : S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                // Hold until the result register is free
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CLEAR:
            begin
                cmd.sweep_write = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_clear = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.commit || cmd.load_clear)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: rtl/dtpb_checker.sv
// ============================================================================
// dtpb_checker
// Port-level checks of the pixel buffer, bound to the top level.
// ============================================================================
`default_nettype none

module dtpb_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                s_axis_tvalid,
    input wire logic                                s_axis_tready,
    input wire logic                                m_axis_tvalid,
    input wire logic                                m_axis_tready,
    input wire logic [dtpb_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input wire logic [dtpb_pkg::STATUS_W-1:0]       m_axis_tuser
);

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Status codes stay within the defined set
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser <= dtpb_pkg::RES_CLEARED)
        else $error("undefined result status");

    // Only a completed read carries color
    a_color_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != dtpb_pkg::RES_READ |-> m_axis_tdata == '0)
        else $error("color on a non-read result");

    // One item at a time: an accept closes the input for the next cycle
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input reopened right after an accept");

endmodule

bind depth_tested_pixel_buffer_core dtpb_checker u_dtpb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

FILE: test/tb_depth_tested_pixel_buffer_core.sv
// ----------------------------------------------------------------------------
// tb_depth_tested_pixel_buffer_core
// Self-checking bench for the z-buffered framebuffer: a directed list of
// fragments, then randomized fragments over several screen sizes. A shadow
// color/depth store predicts the untyped results; all are matched against m_axis.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_depth_tested_pixel_buffer_core;

    import dtpb_pkg::*;

    localparam int MAX_W     = MAX_WIDTH_DEF;
    localparam int MAX_H     = MAX_HEIGHT_DEF;
    localparam int PIX_COUNT = MAX_W * MAX_H;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam int HOLD_AT     = 60;
    localparam int HOLD_CYCLES = 400;
    localparam int NUM_PHASES  = 8;
    localparam int CLEAR_PHASE = 4;
    localparam int CLEAR_SLOT  = 75;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [DEPTH_W-1:0] z;
        logic [COLOR_W-1:0] r;
        logic [COLOR_W-1:0] g;
        logic [COLOR_W-1:0] b;
    } fragment_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COLOR_W-1:0]  r;
        logic [COLOR_W-1:0]  g;
        logic [COLOR_W-1:0]  b;
    } pixel_res_t;

    typedef struct packed {
        fragment_t  frag;
        bit         typed;
        pixel_res_t want;
    } drill_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [KIND_W-1:0]     s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [SIZE_W-1:0]     cfg_data = '0;

    // Shadow framebuffer and size registers
    logic [RGB_W-1:0]   shadow_color [0:PIX_COUNT-1];
    logic [DEPTH_W-1:0] shadow_depth [0:PIX_COUNT-1];
    logic [SIZE_W-1:0]  cur_w = SIZE_RESET;
    logic [SIZE_W-1:0]  cur_h = SIZE_RESET;

    pixel_res_t pixel_results_due [$];
    int         mismatches = 0;
    int         results_taken = 0;
    int         burst_left = 0;
    drill_t     drill [0:19];

    int phase_w [0:NUM_PHASES-1] = '{512, 8, 1, 0, 1023, 300, 20, 512};
    int phase_h [0:NUM_PHASES-1] = '{512, 6, 1, 512, 600, 1, 0, 512};
    int phase_n [0:NUM_PHASES-1] = '{150, 140, 100, 60, 150, 100, 40, 60};

    depth_tested_pixel_buffer_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #32_000_000;
        $display("tb_depth_tested_pixel_buffer_core NOT OK");
        $finish;
    end

    function automatic void blank_store();
        int i;
        for (i = 0; i < PIX_COUNT; i++)
        begin
            shadow_color[i] = WHITE_RGB;
            shadow_depth[i] = FAR_DEPTH;
        end
    endfunction

    function automatic int active_span(logic [SIZE_W-1:0] size, int limit);
        return (size > limit) ? limit : int'(size);
    endfunction

    function automatic bit pixel_slot(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                      output int unsigned addr);
        addr = 0;
        if (x[COORD_W-1] || y[COORD_W-1])
            return 1'b0;
        if (x >= active_span(cur_w, MAX_W) || y >= active_span(cur_h, MAX_H))
            return 1'b0;
        addr = y * MAX_W + x;
        return 1'b1;
    endfunction

    // Depth test and store update for one fragment
    function automatic pixel_res_t zbuf_apply(fragment_t f);
        pixel_res_t  res;
        int unsigned a;
        res = '0;
        res.status = RES_OUT;
        case (f.kind)
            KIND_CLEAR:
            begin
                blank_store();
                res.status = RES_CLEARED;
            end
            KIND_WRITE:
            begin
                if (pixel_slot(f.x, f.y, a))
                begin
                    if (f.z > shadow_depth[a])
                        res.status = RES_REJECTED;
                    else
                    begin
                        shadow_color[a] = {f.r, f.g, f.b};
                        shadow_depth[a] = f.z;
                        res.status = RES_WRITTEN;
                    end
                end
            end
            KIND_READ:
            begin
                if (pixel_slot(f.x, f.y, a))
                begin
                    {res.r, res.g, res.b} = shadow_color[a];
                    res.status = RES_READ;
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    function automatic drill_t mk_row(logic [KIND_W-1:0] kind, int x, int y,
                                      logic [DEPTH_W-1:0] z, logic [RGB_W-1:0] rgb,
                                      bit typed, logic [STATUS_W-1:0] st,
                                      logic [RGB_W-1:0] want_rgb);
        drill_t row;
        row.frag.kind = kind;
        row.frag.x = x[COORD_W-1:0];
        row.frag.y = y[COORD_W-1:0];
        row.frag.z = z;
        {row.frag.r, row.frag.g, row.frag.b} = rgb;
        row.typed = typed;
        row.want.status = st;
        {row.want.r, row.want.g, row.want.b} = want_rgb;
        return row;
    endfunction

    // Mostly near the origin so reads hit earlier writes; some at the far edge
    function automatic logic [COORD_W-1:0] pick_coord(int span);
        int sel;
        int v;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            v = $urandom_range(0, ((span < 12) ? span : 12) + 3) - 2;
        else if (sel < 85)
            v = span - 2 + $urandom_range(0, 3);
        else
            v = $urandom;
        return v[COORD_W-1:0];
    endfunction

    function automatic fragment_t roll_fragment();
        fragment_t   f;
        int unsigned sel;
        int unsigned a;
        sel = $urandom_range(0, 99);
        f.kind = (sel < 52) ? KIND_WRITE : (sel < 92) ? KIND_READ : KIND_UNUSED;
        f.x = pick_coord(active_span(cur_w, MAX_W));
        f.y = pick_coord(active_span(cur_h, MAX_H));
        f.z = DEPTH_W'($urandom);
        {f.r, f.g, f.b} = RGB_W'($urandom);
        sel = $urandom_range(0, 19);
        if (sel == 0)
            f.z = '0;
        else if (sel == 1)
            f.z = FAR_DEPTH;
        else if (sel < 4 && pixel_slot(f.x, f.y, a))
            f.z = shadow_depth[a];
        return f;
    endfunction

    // Offer one fragment; bursts of back-to-back transactions, random gaps between
    task automatic send_fragment(input fragment_t f, input bit typed, input pixel_res_t want);
        pixel_res_t due;
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f.kind;
        s_tdata  <= {f.b, f.g, f.r, f.z, f.y, f.x};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        due = zbuf_apply(f);
        if (typed)
            due = want;
        pixel_results_due.push_back(due);
        burst_left--;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pixel_results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_screen(input int w, input int h);
        cfg_we    <= 1'b1;
        cfg_index <= REG_WIDTH;
        cfg_data  <= w[SIZE_W-1:0];
        @(posedge clk);
        cfg_index <= REG_HEIGHT;
        cfg_data  <= h[SIZE_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_w = w[SIZE_W-1:0];
        cur_h = h[SIZE_W-1:0];
        @(posedge clk);
    endtask

    initial
    begin
        int         i;
        int         p;
        int         n;
        fragment_t  f;
        pixel_res_t none;

        none = '0;
        drill[0]  = mk_row(KIND_READ,     0,     0, 16'h0000, 24'h000000, 1'b1, RES_READ,
                           WHITE_RGB);
        drill[1]  = mk_row(KIND_WRITE,    0,     0, 16'hFFFF, 24'h123456, 1'b0, RES_OUT, 24'h0);
        drill[2]  = mk_row(KIND_WRITE,    0,     0, 16'hFFFF, 24'h654321, 1'b0, RES_OUT, 24'h0);
        drill[3]  = mk_row(KIND_WRITE,    0,     0, 16'h8000, 24'h00FF00, 1'b0, RES_OUT, 24'h0);
        drill[4]  = mk_row(KIND_WRITE,    0,     0, 16'h8001, 24'h0000FF, 1'b0, RES_OUT, 24'h0);
        drill[5]  = mk_row(KIND_WRITE,    0,     0, 16'h0000, 24'hA5A5A5, 1'b0, RES_OUT, 24'h0);
        drill[6]  = mk_row(KIND_READ,     0,     0, 16'h0000, 24'h000000, 1'b0, RES_OUT, 24'h0);
        drill[7]  = mk_row(KIND_WRITE,   -1,     0, 16'h0000, 24'hFFFFFF, 1'b1, RES_OUT, 24'h0);
        drill[8]  = mk_row(KIND_WRITE,    0, -2048, 16'h0000, 24'hFFFFFF, 1'b1, RES_OUT, 24'h0);
        drill[9]  = mk_row(KIND_READ, -2048, -2048, 16'hFFFF, 24'h000000, 1'b1, RES_OUT, 24'h0);
        drill[10] = mk_row(KIND_WRITE,  511,   511, 16'h0000, 24'hFF00AA, 1'b0, RES_OUT, 24'h0);
        drill[11] = mk_row(KIND_READ,   511,   511, 16'h0000, 24'h000000, 1'b0, RES_OUT, 24'h0);
        drill[12] = mk_row(KIND_WRITE,  512,     0, 16'h0000, 24'h102030, 1'b1, RES_OUT, 24'h0);
        drill[13] = mk_row(KIND_READ,     0,   512, 16'h0000, 24'h000000, 1'b1, RES_OUT, 24'h0);
        drill[14] = mk_row(KIND_WRITE, 2047,  2047, 16'h0000, 24'hFFFFFF, 1'b1, RES_OUT, 24'h0);
        drill[15] = mk_row(KIND_UNUSED,   5,     5, 16'h0000, 24'h445566, 1'b1, RES_OUT, 24'h0);
        drill[16] = mk_row(KIND_UNUSED, 511,   511, 16'h0000, 24'hFFFFFF, 1'b1, RES_OUT, 24'h0);
        drill[17] = mk_row(KIND_CLEAR,    0,     0, 16'h0000, 24'h000000, 1'b1, RES_CLEARED,
                           24'h0);
        drill[18] = mk_row(KIND_READ,   511,   511, 16'h0000, 24'h000000, 1'b1, RES_READ,
                           WHITE_RGB);
        drill[19] = mk_row(KIND_READ,     0,     0, 16'h0000, 24'h000000, 1'b1, RES_READ,
                           WHITE_RGB);

        blank_store();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Default 512x512 screen; the sender rides out the power-up sweep
        for (i = 0; i < 20; i++)
            send_fragment(drill[i].frag, drill[i].typed, drill[i].want);

        for (p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            set_screen(phase_w[p], phase_h[p]);
            for (n = 0; n < phase_n[p]; n++)
            begin
                f = roll_fragment();
                if (p == CLEAR_PHASE && n == CLEAR_SLOT)
                    f.kind = KIND_CLEAR;
                send_fragment(f, 1'b0, none);
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("tb_depth_tested_pixel_buffer_core OK");
        else
            $display("tb_depth_tested_pixel_buffer_core NOT OK");
        $finish;
    end

    // Output side: stall pattern re-picked periodically, plus one long hold
    initial
    begin
        int  slot;
        int  mode;
        bit  hold_done;
        slot = 0;
        mode = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!hold_done && results_taken >= HOLD_AT)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                if (slot == 0)
                    mode = $urandom_range(0, 3);
                slot = (slot + 1) % 50;
                case (mode)
                    2:       m_tready <= ($urandom_range(0, 9) < 7);
                    3:       m_tready <= ($urandom_range(0, 9) < 2);
                    default: m_tready <= 1'b1;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        pixel_res_t got;
        pixel_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status = m_tuser;
            got.r = m_tdata[7:0];
            got.g = m_tdata[15:8];
            got.b = m_tdata[23:16];
            results_taken++;
            if (pixel_results_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d rgb %02h%02h%02h",
                             got.status, got.r, got.g, got.b);
            end
            else
            begin
                want = pixel_results_due.pop_front();
                if (got.status !== want.status || got.r !== want.r ||
                    got.g !== want.g || got.b !== want.b)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result %0d: expected status %0d rgb %02h%02h%02h,",
                                  " got status %0d rgb %02h%02h%02h"},
                                 results_taken, want.status, want.r, want.g, want.b,
                                 got.status, got.r, got.g, got.b);
                end
            end
        end
    end

endmodule

`default_nettype wire
